/* src/qau_pkg.sv */
// Shared types, lane indexes and operand builders for the quaternion arithmetic unit.
package qau_pkg;

	localparam int LX = 0;
	localparam int LY = 1;
	localparam int LZ = 2;
	localparam int LW = 3;

	localparam logic signed [32:0] ONE_Q  = 33'sd65536;
	localparam logic signed [32:0] MONE_Q = -33'sd65536;
	localparam logic signed [67:0] HALF_Q = 68'sd32768;

	typedef enum logic [2:0] {
		CMD_MUL   = 3'd0,
		CMD_CONJ  = 3'd1,
		CMD_DOT   = 3'd2,
		CMD_SCALE = 3'd3,
		CMD_LERP  = 3'd4,
		CMD_ROT   = 3'd5
	} cmd_t;

	typedef logic [32:0] opnd_t;
	typedef opnd_t [3:0] vec4_t;
	typedef logic [31:0] word_t;
	typedef word_t [3:0] res4_t;

	typedef struct packed {
		opnd_t p;
		opnd_t q;
		logic  neg;
	} term_t;

	// [lane][term]
	typedef term_t [3:0][3:0] ops_t;

	typedef struct packed {
		cmd_t  cmd;
		vec4_t a;
		logic  ov;
	} side_t;

	function automatic opnd_t sext(input word_t v);
		sext = {v[31], v};
	endfunction

	function automatic term_t mk(input opnd_t p, input opnd_t q, input logic neg);
		term_t t;
		t.p = p;
		t.q = q;
		t.neg = neg;
		mk = t;
	endfunction

	// Hamilton product a*b as four signed terms per lane
	function automatic ops_t ham(input vec4_t a, input vec4_t b);
		ops_t o;
		o[LW][0] = mk(a[LW], b[LW], 1'b0);
		o[LW][1] = mk(a[LX], b[LX], 1'b1);
		o[LW][2] = mk(a[LY], b[LY], 1'b1);
		o[LW][3] = mk(a[LZ], b[LZ], 1'b1);
		o[LX][0] = mk(a[LW], b[LX], 1'b0);
		o[LX][1] = mk(a[LX], b[LW], 1'b0);
		o[LX][2] = mk(a[LY], b[LZ], 1'b0);
		o[LX][3] = mk(a[LZ], b[LY], 1'b1);
		o[LY][0] = mk(a[LW], b[LY], 1'b0);
		o[LY][1] = mk(a[LY], b[LW], 1'b0);
		o[LY][2] = mk(a[LZ], b[LX], 1'b0);
		o[LY][3] = mk(a[LX], b[LZ], 1'b1);
		o[LZ][0] = mk(a[LW], b[LZ], 1'b0);
		o[LZ][1] = mk(a[LZ], b[LW], 1'b0);
		o[LZ][2] = mk(a[LX], b[LY], 1'b0);
		o[LZ][3] = mk(a[LY], b[LX], 1'b1);
		ham = o;
	endfunction

endpackage

/* src/qau_in_if.sv */
// Operation channel: command, quaternions A and B, factor.
interface qau_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] a_x;
	logic [31:0] a_y;
	logic [31:0] a_z;
	logic [31:0] a_w;
	logic [31:0] b_x;
	logic [31:0] b_y;
	logic [31:0] b_z;
	logic [31:0] b_w;
	logic [31:0] factor;

	modport source (output valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, factor,
		input ready);
	modport sink (input valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, factor,
		output ready);
endinterface

/* src/qau_out_if.sv */
// Result channel: four saturated lanes and overflow flag.
interface qau_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] r_x;
	logic [31:0] r_y;
	logic [31:0] r_z;
	logic [31:0] r_w;
	logic        overflow;

	modport source (output valid, r_x, r_y, r_z, r_w, overflow, input ready);
	modport sink (input valid, r_x, r_y, r_z, r_w, overflow, output ready);
endinterface

/* src/qau_pass.sv */
// One multiply pass: product stage, then sum / round / saturate stage.
module qau_pass (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  qau_pkg::ops_t    ops_i,
	input  qau_pkg::side_t   side_i,
	output logic             vld_o,
	output qau_pkg::res4_t   res_o,
	output logic [3:0]       ov_o,
	output qau_pkg::side_t   side_o
);
	import qau_pkg::*;

	logic signed [65:0] prod_d [4][4];
	logic signed [65:0] prod_s1 [4][4];
	side_t              side_s1;
	logic               vld_s1;
	res4_t              res_d;
	logic [3:0]         ov_d;
	res4_t              res_s2;
	logic [3:0]         ov_s2;
	side_t              side_s2;
	logic               vld_s2;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			for (int t = 0; t < 4; t++) begin
				prod_d[l][t] = $signed(ops_i[l][t].p) * $signed(ops_i[l][t].q);
				if (ops_i[l][t].neg) begin
					prod_d[l][t] = -prod_d[l][t];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_d;
			side_s1 <= side_i;
		end
	end

	// round half up: add half LSB, keep bits 47:16, saturate if 67:47 disagree
	always_comb begin
		logic signed [67:0] s;
		for (int l = 0; l < 4; l++) begin
			s = 68'(prod_s1[l][0]) + 68'(prod_s1[l][1]) + 68'(prod_s1[l][2])
				+ 68'(prod_s1[l][3]) + HALF_Q;
			ov_d[l] = !((&s[67:47]) || !(|s[67:47]));
			if (ov_d[l]) begin
				res_d[l] = s[67] ? 32'h8000_0000 : 32'h7fff_ffff;
			end else begin
				res_d[l] = s[47:16];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2  <= res_d;
			ov_s2   <= ov_d;
			side_s2 <= side_s1;
		end
	end

	assign vld_o  = vld_s2;
	assign res_o  = res_s2;
	assign ov_o   = ov_s2;
	assign side_o = side_s2;
endmodule

/* src/quaternion_arithmetic_unit.sv */
// Quaternion arithmetic unit top level: operand select, two multiply passes.
//
//  channel | dir | beat contents
//  req     | in  | cmd, a_x..a_w, b_x..b_w, factor
//  rsp     | out | r_x, r_y, r_z, r_w, overflow
//
// Six register stages: operand select, pass-one products, pass-one round,
// pass-two select, pass-two products, pass-two round (the output register).
// One beat per cycle while the output is not stalled; rotate uses both passes,
// the rest run pass two as an identity. Reset clears only the stage valid bits.
// A stalled output freezes every stage together; req.ready is that enable.
module quaternion_arithmetic_unit (
	input logic  clk,
	input logic  arst_n,
	qau_in_if.sink   req,
	qau_out_if.source rsp
);
	import qau_pkg::*;

	logic  en;
	ops_t  ops1_d;
	side_t side1_d;
	ops_t  ops1_s1;
	side_t side1_s1;
	logic  vld_s1;

	logic  p1_vld;
	res4_t p1_res;
	logic [3:0] p1_ov;
	side_t p1_side;

	ops_t  ops2_d;
	side_t side2_d;
	ops_t  ops2_s4;
	side_t side2_s4;
	logic  vld_s4;

	logic  p2_vld;
	res4_t p2_res;
	logic [3:0] p2_ov;
	side_t p2_side;

	assign en = !p2_vld || rsp.ready;
	assign req.ready = en;

	always_comb begin
		vec4_t a;
		vec4_t b;
		opnd_t f;
		cmd_t  c;
		a[LX] = sext(req.a_x);
		a[LY] = sext(req.a_y);
		a[LZ] = sext(req.a_z);
		a[LW] = sext(req.a_w);
		b[LX] = sext(req.b_x);
		b[LY] = sext(req.b_y);
		b[LZ] = sext(req.b_z);
		b[LW] = sext(req.b_w);
		f = sext(req.factor);
		c = cmd_t'(req.cmd);
		ops1_d = '0;
		case (c)
			CMD_MUL: ops1_d = ham(a, b);
			CMD_CONJ: begin
				for (int l = 0; l < 3; l++) begin
					ops1_d[l][0] = mk(a[l], MONE_Q, 1'b0);
				end
				ops1_d[LW][0] = mk(a[LW], ONE_Q, 1'b0);
			end
			CMD_DOT: begin
				for (int t = 0; t < 4; t++) begin
					ops1_d[LW][t] = mk(a[t], b[t], 1'b0);
				end
			end
			CMD_SCALE: begin
				for (int l = 0; l < 4; l++) begin
					ops1_d[l][0] = mk(a[l], f, 1'b0);
				end
			end
			CMD_LERP: begin
				for (int l = 0; l < 4; l++) begin
					if ($signed(f) <= 0) begin
						ops1_d[l][0] = mk(a[l], ONE_Q, 1'b0);
					end else if ($signed(f) >= ONE_Q) begin
						ops1_d[l][0] = mk(b[l], ONE_Q, 1'b0);
					end else begin
						ops1_d[l][0] = mk(b[l] - a[l], f, 1'b0);
						ops1_d[l][1] = mk(a[l], ONE_Q, 1'b0);
					end
				end
			end
			CMD_ROT: begin
				b[LW] = '0;
				ops1_d = ham(a, b);
			end
			default: ops1_d = '0;
		endcase
		side1_d.cmd = c;
		side1_d.a   = a;
		side1_d.ov  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ops1_s1  <= ops1_d;
			side1_s1 <= side1_d;
		end
	end

	qau_pass u_pass1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s1),
		.ops_i  (ops1_s1),
		.side_i (side1_s1),
		.vld_o  (p1_vld),
		.res_o  (p1_res),
		.ov_o   (p1_ov),
		.side_o (p1_side)
	);

	// rotate: p * conj(A) with w lane dropped; otherwise pass lanes through x1.0
	always_comb begin
		vec4_t p;
		vec4_t cj;
		for (int l = 0; l < 4; l++) begin
			p[l] = sext(p1_res[l]);
		end
		cj[LX] = -p1_side.a[LX];
		cj[LY] = -p1_side.a[LY];
		cj[LZ] = -p1_side.a[LZ];
		cj[LW] = p1_side.a[LW];
		ops2_d = '0;
		if (p1_side.cmd == CMD_ROT) begin
			ops2_d = ham(p, cj);
			ops2_d[LW] = '0;
		end else begin
			for (int l = 0; l < 4; l++) begin
				ops2_d[l][0] = mk(p[l], ONE_Q, 1'b0);
			end
		end
		side2_d     = p1_side;
		side2_d.ov  = |p1_ov;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= p1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ops2_s4  <= ops2_d;
			side2_s4 <= side2_d;
		end
	end

	qau_pass u_pass2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s4),
		.ops_i  (ops2_s4),
		.side_i (side2_s4),
		.vld_o  (p2_vld),
		.res_o  (p2_res),
		.ov_o   (p2_ov),
		.side_o (p2_side)
	);

	assign rsp.valid    = p2_vld;
	assign rsp.r_x      = p2_res[LX];
	assign rsp.r_y      = p2_res[LY];
	assign rsp.r_z      = p2_res[LZ];
	assign rsp.r_w      = p2_res[LW];
	assign rsp.overflow = p2_side.ov || (|p2_ov);
endmodule

/* verif/tb_top.sv */
// Testbench for the quaternion arithmetic unit: random and directed beats checked against a predictor.
module tb_top;
	import qau_pkg::*;

	localparam logic [2:0] CMD_RSV6 = 3'd6;
	localparam logic [2:0] CMD_RSV7 = 3'd7;
	localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
	localparam logic signed [79:0] SAT_LO = -80'sd2147483648;
	localparam logic [31:0] W_MAX = 32'h7fff_ffff;
	localparam logic [31:0] W_MIN = 32'h8000_0000;
	localparam int N_RANDOM = 1600;

	typedef logic signed [79:0] wide_t;
	typedef struct packed {
		wide_t x, y, z, w;
	} qwide_t;
	typedef struct {
		logic [2:0]  cmd;
		logic [31:0] a [4];
		logic [31:0] b [4];
		logic [31:0] factor;
	} op_beat_t;
	typedef struct {
		logic [31:0] r [4];
		logic        ov;
	} res_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qau_in_if  req_if ();
	qau_out_if rsp_if ();

	quaternion_arithmetic_unit uut (.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if));

	always #5 clk = ~clk;

	op_beat_t  pending_ops [$];
	res_beat_t expected_res [$];
	op_beat_t  cur_op;
	int        errors = 0;
	int        rx_count = 0;
	bit        long_stall_done = 0;

	function automatic wide_t sx(input logic [31:0] v);
		wide_t r;
		r = {{48{v[31]}}, v};
		return r;
	endfunction

	// round half up to Q16.16, then clamp to 32 bits
	function automatic logic [31:0] round_sat(input wide_t s, inout bit ov);
		wide_t v;
		v = (s + 80'sd32768) >>> 16;
		if (v > SAT_HI) begin
			ov = 1;
			return W_MAX;
		end
		if (v < SAT_LO) begin
			ov = 1;
			return W_MIN;
		end
		return v[31:0];
	endfunction

	function automatic qwide_t hamilton_sums(input qwide_t a, input qwide_t b);
		qwide_t s;
		s.w = a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z;
		s.x = a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y;
		s.y = a.w * b.y + a.y * b.w + a.z * b.x - a.x * b.z;
		s.z = a.w * b.z + a.z * b.w + a.x * b.y - a.y * b.x;
		return s;
	endfunction

	function automatic res_beat_t quat_result(input op_beat_t op);
		res_beat_t res;
		qwide_t a, b, s, p, c;
		wide_t f, d;
		bit ov, scratch;
		a = '{sx(op.a[LX]), sx(op.a[LY]), sx(op.a[LZ]), sx(op.a[LW])};
		b = '{sx(op.b[LX]), sx(op.b[LY]), sx(op.b[LZ]), sx(op.b[LW])};
		f = sx(op.factor);
		ov = 0;
		scratch = 0;
		for (int i = 0; i < 4; i++)
			res.r[i] = '0;
		case (op.cmd)
			CMD_MUL: begin
				s = hamilton_sums(a, b);
				res.r[LX] = round_sat(s.x, ov);
				res.r[LY] = round_sat(s.y, ov);
				res.r[LZ] = round_sat(s.z, ov);
				res.r[LW] = round_sat(s.w, ov);
			end
			CMD_CONJ: begin
				for (int i = 0; i < 3; i++)
					res.r[i] = round_sat((-sx(op.a[i])) <<< 16, ov);
				res.r[LW] = op.a[LW];
			end
			CMD_DOT: begin
				d = a.x * b.x + a.y * b.y + a.z * b.z + a.w * b.w;
				res.r[LW] = round_sat(d, ov);
			end
			CMD_SCALE: begin
				for (int i = 0; i < 4; i++)
					res.r[i] = round_sat(sx(op.a[i]) * f, ov);
			end
			CMD_LERP: begin
				if (f <= 0)
					res.r = op.a;
				else if (f >= 80'sd65536)
					res.r = op.b;
				else
					for (int i = 0; i < 4; i++)
						res.r[i] = round_sat((sx(op.b[i]) - sx(op.a[i])) * f
							+ (sx(op.a[i]) <<< 16), ov);
			end
			CMD_ROT: begin
				b.w = 0;
				s = hamilton_sums(a, b);
				p.x = sx(round_sat(s.x, ov));
				p.y = sx(round_sat(s.y, ov));
				p.z = sx(round_sat(s.z, ov));
				p.w = sx(round_sat(s.w, ov));
				c = '{-a.x, -a.y, -a.z, a.w};
				s = hamilton_sums(p, c);
				res.r[LX] = round_sat(s.x, ov);
				res.r[LY] = round_sat(s.y, ov);
				res.r[LZ] = round_sat(s.z, ov);
				res.r[LW] = round_sat(s.w, scratch);
				res.r[LW] = '0;
			end
			default: ;
		endcase
		res.ov = ov;
		return res;
	endfunction

	function automatic logic [31:0] rand_word(input int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($urandom_range(0, 262143)) - 32'd131072;
			2: return ($urandom_range(0, 1)) ? W_MAX : W_MIN;
			default: return 32'($urandom_range(0, 65536)) - 32'd32768;
		endcase
	endfunction

	function automatic op_beat_t make_op(input logic [2:0] cmd, input logic [31:0] av,
		input logic [31:0] bv, input logic [31:0] fv);
		op_beat_t op;
		op.cmd = cmd;
		for (int i = 0; i < 4; i++) begin
			op.a[i] = av;
			op.b[i] = bv;
		end
		op.factor = fv;
		return op;
	endfunction

	function automatic op_beat_t random_op();
		op_beat_t op;
		int mode;
		mode = $urandom_range(0, 9);
		op.cmd = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		for (int i = 0; i < 4; i++) begin
			// mostly near-unit magnitudes so the interesting arithmetic is not all saturated
			op.a[i] = rand_word(mode < 3 ? 0 : mode < 8 ? 1 : mode == 8 ? 2 : 3);
			op.b[i] = rand_word(mode < 3 ? 0 : mode < 8 ? 1 : mode == 8 ? 2 : 3);
		end
		case ($urandom_range(0, 7))
			0: op.factor = $urandom;
			1: op.factor = 32'($urandom_range(65536, 65537)) - 32'd1;
			2: op.factor = 32'($urandom_range(0, 2)) - 32'd1;
			default: op.factor = 32'($urandom_range(1, 65535));
		endcase
		return op;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 19);
		if (k < 14)
			return 0;
		if (k < 19)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	int  tx_gap = 0;
	bit  tx_burst = 0;
	int  tx_sent = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.cmd <= '0;
			{req_if.a_x, req_if.a_y, req_if.a_z, req_if.a_w} <= '0;
			{req_if.b_x, req_if.b_y, req_if.b_z, req_if.b_w} <= '0;
			req_if.factor <= '0;
		end else begin
			if (req_if.valid && req_if.ready)
				expected_res.push_back(quat_result(cur_op));
			if (!req_if.valid || req_if.ready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					req_if.valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					cur_op = pending_ops.pop_front();
					req_if.valid <= 1'b1;
					req_if.cmd <= cur_op.cmd;
					req_if.a_x <= cur_op.a[LX];
					req_if.a_y <= cur_op.a[LY];
					req_if.a_z <= cur_op.a[LZ];
					req_if.a_w <= cur_op.a[LW];
					req_if.b_x <= cur_op.b[LX];
					req_if.b_y <= cur_op.b[LY];
					req_if.b_z <= cur_op.b[LZ];
					req_if.b_w <= cur_op.b[LW];
					req_if.factor <= cur_op.factor;
					tx_sent <= tx_sent + 1;
					if (tx_sent % 128 == 0)
						tx_burst <= $urandom_range(0, 2) == 0;
					tx_gap <= tx_burst ? 0 : gap_len();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	int rx_gap = 0;
	int long_hold = 0;
	always @(posedge clk or negedge arst_n) begin
		res_beat_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				rx_count <= rx_count + 1;
				if (expected_res.size() == 0) begin
					$display("%0t: unexpected beat r=%h %h %h %h ov=%b", $time, rsp_if.r_x,
						rsp_if.r_y, rsp_if.r_z, rsp_if.r_w, rsp_if.overflow);
					errors++;
				end else begin
					want = expected_res.pop_front();
					if (rsp_if.r_x !== want.r[LX] || rsp_if.r_y !== want.r[LY] ||
						rsp_if.r_z !== want.r[LZ] || rsp_if.r_w !== want.r[LW] ||
						rsp_if.overflow !== want.ov) begin
						$display("%0t: mismatch expected %h %h %h %h ov=%b actual %h %h %h %h ov=%b",
							$time, want.r[LX], want.r[LY], want.r[LZ], want.r[LW], want.ov,
							rsp_if.r_x, rsp_if.r_y, rsp_if.r_z, rsp_if.r_w, rsp_if.overflow);
						errors++;
					end
				end
			end
			if (!long_stall_done && rx_count == 400) begin
				long_stall_done <= 1;
				long_hold <= 150;
				rsp_if.ready <= 1'b0;
			end else if (long_hold > 0) begin
				long_hold <= long_hold - 1;
				rsp_if.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				rx_gap <= gap_len();
			end
		end
	end

	task automatic wait_drained();
		while (pending_ops.size() != 0 || expected_res.size() != 0 || req_if.valid)
			@(posedge clk);
	endtask

	initial begin
		logic [31:0] hi, lo, one;
		hi = W_MAX;
		lo = W_MIN;
		one = 32'd65536;
		pending_ops.push_back(make_op(CMD_MUL, hi, hi, 0));
		pending_ops.push_back(make_op(CMD_MUL, lo, lo, 0));
		pending_ops.push_back(make_op(CMD_MUL, one, one, 0));
		pending_ops.push_back(make_op(CMD_CONJ, lo, 0, 0));
		pending_ops.push_back(make_op(CMD_CONJ, hi, 0, 0));
		pending_ops.push_back(make_op(CMD_DOT, hi, hi, 0));
		pending_ops.push_back(make_op(CMD_DOT, lo, hi, 0));
		pending_ops.push_back(make_op(CMD_SCALE, lo, 0, lo));
		pending_ops.push_back(make_op(CMD_SCALE, hi, 0, 32'd32768));
		pending_ops.push_back(make_op(CMD_SCALE, 32'd1, 0, 32'd32768));
		pending_ops.push_back(make_op(CMD_LERP, lo, hi, 0));
		pending_ops.push_back(make_op(CMD_LERP, lo, hi, lo));
		pending_ops.push_back(make_op(CMD_LERP, lo, hi, one));
		pending_ops.push_back(make_op(CMD_LERP, lo, hi, hi));
		pending_ops.push_back(make_op(CMD_LERP, lo, hi, 32'd65535));
		pending_ops.push_back(make_op(CMD_LERP, hi, lo, 32'd1));
		pending_ops.push_back(make_op(CMD_LERP, one, 0, 32'd32768));
		pending_ops.push_back(make_op(CMD_ROT, one, one, 0));
		pending_ops.push_back(make_op(CMD_ROT, hi, hi, 0));
		pending_ops.push_back(make_op(CMD_ROT, lo, hi, 0));
		pending_ops.push_back(make_op(CMD_RSV6, hi, hi, hi));
		pending_ops.push_back(make_op(CMD_RSV7, lo, lo, lo));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();
		// second half goes in only after the first has fully come back
		for (int i = 0; i < N_RANDOM / 2; i++)
			pending_ops.push_back(random_op());
		wait_drained();
		repeat (20) @(posedge clk);
		for (int i = 0; i < N_RANDOM / 2; i++)
			pending_ops.push_back(random_op());
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_res.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule

/* filelist.f */
src/qau_pkg.sv
src/qau_in_if.sv
src/qau_out_if.sv
src/qau_pass.sv
src/quaternion_arithmetic_unit.sv
verif/tb_top.sv
